// File: rtl/smf_pkg.sv
`timescale 1ns / 1ps

package smf_pkg;

   localparam int MAX_WINDOW   = 8;
   localparam int SAMPLE_WIDTH = 24;

   // Window positions and counts
   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   // Stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((SAMPLE_WIDTH + CNT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - SAMPLE_WIDTH - CNT_W;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_SIZE    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STRICT_INVALID = 1'd1;

   localparam logic [CNT_W-1:0] WINDOW_MIN   = CNT_W'(2);
   localparam logic [CNT_W-1:0] WINDOW_MAX   = CNT_W'(MAX_WINDOW);
   localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(3);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef sample_type [MAX_WINDOW-1:0]    sample_line_type;
   typedef logic [MAX_WINDOW-1:0]          valid_line_type;

   typedef struct packed {
      sample_type       median;
      logic             median_valid;
      logic [CNT_W-1:0] valid_count;
   } result_type;

endpackage

// File: rtl/smf_median.sv
`timescale 1ns / 1ps

module smf_median (
   input  smf_pkg::sample_line_type        sample_line,
   input  smf_pkg::valid_line_type         valid_line,
   input  logic [smf_pkg::CNT_W-1:0]       window_size,
   input  logic                            strict_invalid,
   output smf_pkg::result_type             result
);
   import smf_pkg::*;

   logic [MAX_WINDOW-1:0] used;
   logic [CNT_W-1:0]      rank [MAX_WINDOW];
   logic [CNT_W-1:0]      count;
   logic [CNT_W-1:0]      lo_rank;
   logic [CNT_W-1:0]      hi_rank;
   sample_type            lo_val;
   sample_type            hi_val;
   logic signed [SAMPLE_WIDTH:0] pair_sum;
   logic                  ok;

   // Samples inside the window that hold a number
   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         used[i] = valid_line[i] && (CNT_W'(i) < window_size);
      end
   end

   // Rank of each used sample among the used ones; ties broken by position
   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         rank[i] = '0;
         for (int j = 0; j < MAX_WINDOW; j++) begin
            if (j != i && used[j] &&
                ((sample_line[j] < sample_line[i]) ||
                 ((sample_line[j] == sample_line[i]) && (j < i)))) begin
               rank[i] = rank[i] + CNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      count = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         count = count + CNT_W'(used[i]);
      end
   end

   // Odd count: both middles are the same sample
   assign lo_rank = (count - CNT_W'(1)) >> 1;
   assign hi_rank = count >> 1;

   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (used[i] && rank[i] == lo_rank) lo_val = lo_val | sample_line[i];
         if (used[i] && rank[i] == hi_rank) hi_val = hi_val | sample_line[i];
      end
   end

   // Arithmetic shift of the sum rounds toward minus infinity
   assign pair_sum = {lo_val[SAMPLE_WIDTH-1], lo_val} + {hi_val[SAMPLE_WIDTH-1], hi_val};

   assign ok = (count != '0) && !(strict_invalid && (count != window_size));

   assign result.median       = ok ? sample_type'(pair_sum[SAMPLE_WIDTH:1]) : '0;
   assign result.median_valid = ok;
   assign result.valid_count  = count;

endmodule

// File: rtl/sliding_median_filter.sv
`timescale 1ns / 1ps

// Channel   Direction  Accept edge             Payload
// req_*     in         req_tvalid & req_tready  tdata: sample; tuser: sample_valid
// rsp_*     out        rsp_tvalid & rsp_tready  tdata: median, valid_count; tuser: median_valid
// csr_*     in         csr_we                   csr_index selects, csr_wdata carries value
//
// One request per cycle while the response is not stalled. The delay line
// is the input register; the rank-select network feeds the response register.
// No response is given while fewer than window_size samples have arrived.
// Reset (synchronous, active high) empties the line, window_size = 3, lenient.
// A stalled response holds; the line still takes one more request meanwhile.

module sliding_median_filter (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [smf_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [23:0] sample
   input  logic                              req_tuser,  // [0] sample_valid
   // Response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [smf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // [23:0] median, [27:24] valid_count
   output logic                              rsp_tuser,  // [0] median_valid
   // Configuration writes
   input  logic                              csr_we,
   input  logic [smf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [smf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import smf_pkg::*;

   // Configuration
   logic [CNT_W-1:0] window_size_ff;
   logic             strict_ff;
   logic [CNT_W-1:0] size_eff;

   // Delay line, newest sample at position 0
   sample_line_type  sample_line_ff;
   valid_line_type   valid_line_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;

   // Line holds a request whose response is not yet registered
   logic             line_vld_ff;

   // Response register
   logic             rsp_vld_ff;
   result_type       rsp_ff;
   result_type       result;

   logic             advance;
   logic             req_accept;
   logic             emit;

   // Out-of-range window sizes clamp to the legal range
   always_comb begin
      if (window_size_ff < WINDOW_MIN) begin
         size_eff = WINDOW_MIN;
      end else if (window_size_ff > WINDOW_MAX) begin
         size_eff = WINDOW_MAX;
      end else begin
         size_eff = window_size_ff;
      end
   end

   // Advance the response register when it is empty or being drained
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !line_vld_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign fill_in    = (fill_ff < WINDOW_MAX) ? fill_ff + CNT_W'(1) : fill_ff;
   assign emit       = fill_ff >= size_eff;

   smf_median u_median (
      .sample_line    (sample_line_ff),
      .valid_line     (valid_line_ff),
      .window_size    (size_eff),
      .strict_invalid (strict_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_RESET;
         strict_ff      <= 1'b0;
         valid_line_ff  <= '0;
         fill_ff        <= '0;
         line_vld_ff    <= 1'b0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_WINDOW_SIZE:    window_size_ff <= csr_wdata[CNT_W-1:0];
               REG_STRICT_INVALID: strict_ff      <= csr_wdata[0];
               default: ;
            endcase
         end
         if (advance) begin
            rsp_vld_ff  <= line_vld_ff && emit;
         end
         // Mark a new request pending; drop the flag once its response slot opens
         if (req_accept) begin
            valid_line_ff <= {valid_line_ff[MAX_WINDOW-2:0], req_tuser};
            fill_ff       <= fill_in;
            line_vld_ff   <= 1'b1;
         end else if (advance) begin
            line_vld_ff   <= 1'b0;
         end
      end
   end

   // Sample payload carries no reset; unused positions are masked by valid bits
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_line_ff <= {sample_line_ff[MAX_WINDOW-2:0],
                            sample_type'(req_tdata[SAMPLE_WIDTH-1:0])};
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff.valid_count, rsp_ff.median};
   assign rsp_tuser  = rsp_ff.median_valid;

endmodule
